/* rtl/core/usbser_pkg.sv */
// Shared types and constants for the serial endpoint register block.
package usbser_pkg;

   localparam int IDX_W  = 6;
   localparam int DATA_W = 32;
   localparam int BYTE_W = 8;
   localparam int ROOM_W = 7;

   // Opcodes of an input word
   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_HOST  = 2'd2;

   // Result kinds
   localparam logic [1:0] KIND_READ = 2'd0;
   localparam logic [1:0] KIND_ACK  = 2'd1;
   localparam logic [1:0] KIND_BYTE = 2'd2;

   // Register indexes
   localparam logic [IDX_W-1:0] IDX_DATA      = 6'd0;
   localparam logic [IDX_W-1:0] IDX_CONF      = 6'd1;
   localparam logic [IDX_W-1:0] IDX_RAW       = 6'd2;
   localparam logic [IDX_W-1:0] IDX_STATUS    = 6'd3;
   localparam logic [IDX_W-1:0] IDX_ENABLE    = 6'd4;
   localparam logic [IDX_W-1:0] IDX_CLEAR     = 6'd5;
   localparam logic [IDX_W-1:0] IDX_FIRST_GEN = 6'd6;

   // Bit positions
   localparam int CONF_DONE_BIT  = 0;
   localparam int CONF_FREE_BIT  = 1;
   localparam int CONF_AVAIL_BIT = 2;
   localparam int INT_RECV_BIT   = 2;
   localparam int INT_EMPTY_BIT  = 3;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [IDX_W-1:0]  reg_index;
      logic [DATA_W-1:0] write_data;
      logic [BYTE_W-1:0] host_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]        result_kind;
      logic [DATA_W-1:0] read_data;
      logic [BYTE_W-1:0] out_byte;
      logic              last_of_run;
      logic              irq_level;
      logic [ROOM_W-1:0] rx_room;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic exec;
      logic load_result;
      logic load_byte;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic flush_go;
      logic rsp_last;
   } ctrl_sts_type;

endpackage

/* rtl/core/usbser_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module usbser_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and read, read data registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/usbser_dp.sv */
// Datapath: request register, buffers, interrupt registers and result register.
module usbser_dp
   import usbser_pkg::*;
#(
   parameter int EP_SIZE   = 64,
   parameter int RX_SIZE   = 64,
   parameter int REG_COUNT = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  req_type      req_data,
   output rsp_type      rsp_data,
   input  ctrl_cmd_type cmd,
   output ctrl_sts_type sts
);

   localparam int TX_CW  = $clog2(EP_SIZE + 1);
   localparam int TX_AW  = (EP_SIZE > 1) ? $clog2(EP_SIZE) : 1;
   localparam int RX_CW  = $clog2(RX_SIZE + 1);
   localparam int RX_AW  = (RX_SIZE > 1) ? $clog2(RX_SIZE) : 1;
   localparam int REG_AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
   localparam logic [IDX_W:0] REG_LIMIT = (IDX_W + 1)'(REG_COUNT);

   typedef enum logic [1:0] {SRC_CONST, SRC_RING, SRC_REGS} rd_src_type;

   req_type                req_ff;
   logic [TX_CW-1:0]       tx_count_ff, tx_count_in;
   logic [RX_AW-1:0]       rx_head_ff, rx_head_in;
   logic [RX_AW-1:0]       rx_tail_ff, rx_tail_in;
   logic [RX_CW-1:0]       rx_count_ff, rx_count_in;
   logic [DATA_W-1:0]      raw_ff, raw_in;
   logic [DATA_W-1:0]      enable_ff, enable_in;
   logic [DATA_W-1:0]      status_ff, status_in;
   logic [REG_COUNT-1:0]   reg_valid_ff, reg_valid_in;
   logic [TX_CW-1:0]       fl_len_ff, fl_idx_ff;
   rd_src_type             rd_src_ff, rd_src_in;
   logic [DATA_W-1:0]      rd_val_ff, rd_val_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   in_range, is_read, is_write, is_host;
   logic                   wr_data, wr_done, wr_clear, wr_enable, wr_raw, wr_gen;
   logic                   rd_pop, host_store, irq_upd;
   logic [REG_AW-1:0]      reg_addr;
   logic [BYTE_W-1:0]      tx_q, rx_q;
   logic [DATA_W-1:0]      reg_q, rd_sel;
   logic [RX_CW+ROOM_W-1:0] room_wide;

   // Decode the held request
   always_comb begin
      in_range   = {1'b0, req_ff.reg_index} < REG_LIMIT;
      is_read    = req_ff.opcode == OP_READ;
      is_write   = req_ff.opcode == OP_WRITE;
      is_host    = req_ff.opcode == OP_HOST;
      reg_addr   = req_ff.reg_index[REG_AW-1:0];
      wr_data    = is_write && in_range && req_ff.reg_index == IDX_DATA;
      wr_done    = is_write && in_range && req_ff.reg_index == IDX_CONF
                   && req_ff.write_data[CONF_DONE_BIT];
      wr_clear   = is_write && in_range && req_ff.reg_index == IDX_CLEAR;
      wr_enable  = is_write && in_range && req_ff.reg_index == IDX_ENABLE;
      wr_raw     = is_write && in_range && req_ff.reg_index == IDX_RAW;
      wr_gen     = is_write && in_range && req_ff.reg_index >= IDX_FIRST_GEN;
      rd_pop     = is_read && in_range && req_ff.reg_index == IDX_DATA
                   && rx_count_ff != '0;
      host_store = is_host && rx_count_ff < RX_CW'(RX_SIZE);
      sts.flush_go = (wr_data && tx_count_ff == TX_CW'(EP_SIZE - 1))
                     || (wr_done && tx_count_ff != '0);
      sts.rsp_last = rsp_ff.last_of_run;
   end

   // Next state of counters and interrupt registers for one operation
   always_comb begin
      tx_count_in  = tx_count_ff;
      rx_head_in   = rx_head_ff;
      rx_tail_in   = rx_tail_ff;
      rx_count_in  = rx_count_ff;
      raw_in       = raw_ff;
      enable_in    = enable_ff;
      status_in    = status_ff;
      reg_valid_in = reg_valid_ff;
      irq_upd      = 1'b0;

      if (wr_data) begin
         tx_count_in = tx_count_ff + TX_CW'(1);
      end
      if (sts.flush_go) begin
         tx_count_in = '0;
         raw_in[INT_EMPTY_BIT] = 1'b1;
         irq_upd = 1'b1;
      end
      if (wr_raw) begin
         raw_in = req_ff.write_data;
      end
      if (wr_clear) begin
         raw_in  = raw_ff & ~req_ff.write_data;
         irq_upd = 1'b1;
      end
      if (wr_enable) begin
         enable_in = req_ff.write_data;
         irq_upd   = 1'b1;
      end
      if (wr_gen) begin
         reg_valid_in[reg_addr] = 1'b1;
      end
      if (is_host) begin
         raw_in[INT_RECV_BIT] = 1'b1;
         irq_upd = 1'b1;
         if (host_store) begin
            rx_tail_in  = (rx_tail_ff == RX_AW'(RX_SIZE - 1)) ? '0
                          : rx_tail_ff + RX_AW'(1);
            rx_count_in = rx_count_ff + RX_CW'(1);
         end
      end
      if (rd_pop) begin
         rx_head_in  = (rx_head_ff == RX_AW'(RX_SIZE - 1)) ? '0
                       : rx_head_ff + RX_AW'(1);
         rx_count_in = rx_count_ff - RX_CW'(1);
      end
      if (irq_upd) begin
         status_in = raw_in & enable_in;
      end
   end

   // Pick the source of a read response
   always_comb begin
      rd_src_in = SRC_CONST;
      rd_val_in = '0;
      if (in_range) begin
         unique case (req_ff.reg_index)
            IDX_DATA: begin
               if (rx_count_ff != '0) begin
                  rd_src_in = SRC_RING;
               end
            end
            IDX_CONF: begin
               rd_val_in[CONF_FREE_BIT]  = tx_count_ff < TX_CW'(EP_SIZE);
               rd_val_in[CONF_AVAIL_BIT] = rx_count_ff != '0;
            end
            IDX_RAW:    rd_val_in = raw_ff;
            IDX_STATUS: rd_val_in = status_ff;
            IDX_ENABLE: rd_val_in = enable_ff;
            IDX_CLEAR:  rd_val_in = '0;
            default: begin
               if (reg_valid_ff[reg_addr]) begin
                  rd_src_in = SRC_REGS;
               end
            end
         endcase
      end
   end

   // Build the result word
   always_comb begin
      if (rd_src_ff == SRC_RING) begin
         rd_sel = {{(DATA_W - BYTE_W){1'b0}}, rx_q};
      end else if (rd_src_ff == SRC_REGS) begin
         rd_sel = reg_q;
      end else begin
         rd_sel = rd_val_ff;
      end
      room_wide = (RX_CW + ROOM_W)'(RX_SIZE) - (RX_CW + ROOM_W)'(rx_count_ff);

      rsp_in = rsp_ff;
      rsp_in.irq_level = status_ff != '0;
      rsp_in.rx_room   = room_wide[ROOM_W-1:0];
      if (cmd.load_result) begin
         rsp_in.result_kind = is_read ? KIND_READ : KIND_ACK;
         rsp_in.read_data   = is_read ? rd_sel : '0;
         rsp_in.out_byte    = '0;
         rsp_in.last_of_run = 1'b1;
      end else begin
         rsp_in.result_kind = KIND_BYTE;
         rsp_in.read_data   = '0;
         rsp_in.out_byte    = tx_q;
         rsp_in.last_of_run = fl_idx_ff == fl_len_ff - TX_CW'(1);
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tx_count_ff  <= '0;
         rx_head_ff   <= '0;
         rx_tail_ff   <= '0;
         rx_count_ff  <= '0;
         raw_ff       <= '0;
         enable_ff    <= '0;
         status_ff    <= '0;
         reg_valid_ff <= '0;
      end else if (cmd.exec) begin
         tx_count_ff  <= tx_count_in;
         rx_head_ff   <= rx_head_in;
         rx_tail_ff   <= rx_tail_in;
         rx_count_ff  <= rx_count_in;
         raw_ff       <= raw_in;
         enable_ff    <= enable_in;
         status_ff    <= status_in;
         reg_valid_ff <= reg_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.exec) begin
         rd_src_ff <= rd_src_in;
         rd_val_ff <= rd_val_in;
         fl_idx_ff <= '0;
         fl_len_ff <= wr_data ? TX_CW'(EP_SIZE) : tx_count_ff;
      end
      if (cmd.load_byte) begin
         fl_idx_ff <= fl_idx_ff + TX_CW'(1);
      end
      if (cmd.load_result || cmd.load_byte) begin
         rsp_ff <= rsp_in;
      end
   end

   usbser_ram #(.WIDTH(BYTE_W), .DEPTH(EP_SIZE), .AW(TX_AW)) u_tx_ram (
      .clock   (clock),
      .wr_en   (cmd.exec && wr_data),
      .wr_addr (tx_count_ff[TX_AW-1:0]),
      .wr_data (req_ff.write_data[BYTE_W-1:0]),
      .rd_addr (fl_idx_ff[TX_AW-1:0]),
      .rd_data (tx_q)
   );

   usbser_ram #(.WIDTH(BYTE_W), .DEPTH(RX_SIZE), .AW(RX_AW)) u_rx_ram (
      .clock   (clock),
      .wr_en   (cmd.exec && host_store),
      .wr_addr (rx_tail_ff),
      .wr_data (req_ff.host_byte),
      .rd_addr (rx_head_ff),
      .rd_data (rx_q)
   );

   usbser_ram #(.WIDTH(DATA_W), .DEPTH(REG_COUNT), .AW(REG_AW)) u_reg_ram (
      .clock   (clock),
      .wr_en   (cmd.exec && wr_gen),
      .wr_addr (reg_addr),
      .wr_data (req_ff.write_data),
      .rd_addr (reg_addr),
      .rd_data (reg_q)
   );

   assign rsp_data = rsp_ff;

`ifndef SYNTHESIS
   a_tx_below_full: assert property (@(posedge clock) disable iff (reset)
      tx_count_ff < TX_CW'(EP_SIZE))
      else $error("transmit count reached endpoint size at rest");

   a_rx_bounded: assert property (@(posedge clock) disable iff (reset)
      rx_count_ff <= RX_CW'(RX_SIZE))
      else $error("receive count above ring size");

   a_byte_in_run: assert property (@(posedge clock) disable iff (reset)
      cmd.load_byte |-> (fl_idx_ff < fl_len_ff))
      else $error("flush read beyond buffered bytes");
`endif

endmodule

/* rtl/core/usbser_ctrl.sv */
// Controller: sequences one request through execute, read wait, flush and response.
module usbser_ctrl
   import usbser_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output ctrl_cmd_type cmd,
   input  ctrl_sts_type sts
);

   typedef enum logic [2:0] {
      S_IDLE, S_EXEC, S_WAIT, S_FL_RD, S_FL_LD, S_RESP
   } state_type;

   state_type state_ff;
   logic      req_ready_ff;
   logic      rsp_valid_ff;

   // Commands to the datapath
   always_comb begin
      cmd.capture     = state_ff == S_IDLE && req_valid && req_ready_ff;
      cmd.exec        = state_ff == S_EXEC;
      cmd.load_result = state_ff == S_WAIT;
      cmd.load_byte   = state_ff == S_FL_LD;
   end

   // State and registered handshake outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid && req_ready_ff) begin
                  state_ff     <= S_EXEC;
                  req_ready_ff <= 1'b0;
               end else begin
                  req_ready_ff <= 1'b1;
               end
            end
            S_EXEC: begin
               state_ff <= sts.flush_go ? S_FL_RD : S_WAIT;
            end
            S_WAIT: begin
               state_ff     <= S_RESP;
               rsp_valid_ff <= 1'b1;
            end
            S_FL_RD: begin
               state_ff <= S_FL_LD;
            end
            S_FL_LD: begin
               state_ff     <= S_RESP;
               rsp_valid_ff <= 1'b1;
            end
            S_RESP: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  if (sts.rsp_last) begin
                     state_ff     <= S_IDLE;
                     req_ready_ff <= 1'b1;
                  end else begin
                     state_ff <= S_FL_RD;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_ready_ff && rsp_valid_ff))
      else $error("request taken while a response is pending");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff == S_WAIT) || $past(state_ff == S_FL_LD)))
      else $error("response raised without a loaded result");
`endif

endmodule

/* rtl/core/usb_serial_endpoint_regs_top.sv */
// Serial endpoint register block: top level joining controller and datapath.
//
// Request channel (req_valid/req_ready/req_data) carries one word: a bus read,
// a bus write or one byte arriving from the host. Response channel
// (rsp_valid/rsp_ready/rsp_data) returns one word per result; last_of_run
// marks the final result of a request.
// A request is taken only when the block is idle. A read or an acknowledged
// operation raises rsp_valid after the execute state (with the memory read)
// and the result load state. With a ready receiver the block returns to idle
// with req_ready set as the response is taken.
// A flush streams the transmit buffer byte by byte (RAM read, result load,
// response handshake), up to EP_SIZE bytes for one write.
// Reset empties both buffers, zeros the interrupt registers and marks the
// general registers unwritten, so they read as zero; no clearing pass is
// needed. The response register is not reset; irq_level is updated with the
// next result. req_ready is registered and is set in idle after reset.
// When the receiver stalls, the response word holds in its output register
// and the block takes no further request until every result is delivered.
module usb_serial_endpoint_regs_top
   import usbser_pkg::*;
#(
   parameter int EP_SIZE   = 64,
   parameter int RX_SIZE   = 64,
   parameter int REG_COUNT = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   usbser_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   usbser_dp #(
      .EP_SIZE   (EP_SIZE),
      .RX_SIZE   (RX_SIZE),
      .REG_COUNT (REG_COUNT)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .rsp_data (rsp_data),
      .cmd      (cmd),
      .sts      (sts)
   );

endmodule
